### rtl/core/wtr_pkg.sv
// Shared types and band constants for the wavelength to RGB pipeline.
package wtr_pkg;

  // Input wavelength word width (fixed point, nm).
  localparam int WAVE_WIDTH = 14;
  // Bits for the integer nm part of any band edge (all edges below 1024 nm).
  localparam int NM_BITS    = 10;
  // Width of a ramp span in nm.
  localparam int SPAN_BITS  = 10;
  // Register stages from input to color output.
  localparam int PIPE_STAGES = 5;

  // Band edges in whole nm.
  localparam int WL_UV_START  = 300;
  localparam int WL_VIOLET    = 380;
  localparam int WL_FAC_FLAT  = 420;
  localparam int WL_BLUE      = 440;
  localparam int WL_CYAN      = 490;
  localparam int WL_GREEN     = 510;
  localparam int WL_ORANGE    = 580;
  localparam int WL_RED       = 645;
  localparam int WL_FAC_FALL  = 700;
  localparam int WL_NIR       = 780;
  localparam int WL_FAC_END   = 781;
  localparam int WL_IR_END    = 880;

  // Offsets of the intensity ramps, in nm (3 * 40 and 3 * 80 - 7).
  localparam int FAC_RISE_BASE = 120;
  localparam int FAC_FALL_BASE = 233;

  // Where a color channel level comes from.
  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_ONE,
    SRC_RAMP
  } chan_src_t;

  // Where the edge intensity factor comes from.
  typedef enum logic [1:0] {
    FAC_LOW,
    FAC_ONE,
    FAC_RAMP
  } fac_src_t;

  // Ramp divisor, in nm of span (factor ramps carry their 10x).
  typedef enum logic [3:0] {
    DIV_20,
    DIV_50,
    DIV_60,
    DIV_65,
    DIV_70,
    DIV_80,
    DIV_99,
    DIV_400,
    DIV_800
  } div_t;

  typedef struct packed {
    chan_src_t red;
    chan_src_t green;
    chan_src_t blue;
    fac_src_t  factor;
  } route_t;

  function automatic logic [SPAN_BITS-1:0] div_span(div_t d);
    unique case (d)
      DIV_20:  div_span = SPAN_BITS'(20);
      DIV_50:  div_span = SPAN_BITS'(50);
      DIV_60:  div_span = SPAN_BITS'(60);
      DIV_65:  div_span = SPAN_BITS'(65);
      DIV_70:  div_span = SPAN_BITS'(70);
      DIV_80:  div_span = SPAN_BITS'(80);
      DIV_99:  div_span = SPAN_BITS'(99);
      DIV_400: div_span = SPAN_BITS'(400);
      DIV_800: div_span = SPAN_BITS'(800);
      default: div_span = SPAN_BITS'(800);
    endcase
  endfunction

endpackage

### rtl/core/wtr_decode.sv
// Stage 1: band decode, ramp numerators and pre-scaled dividends.
module wtr_decode import wtr_pkg::*; #(
  parameter int WAVE_FRAC_BITS   = 4,
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic                               clk,
  input  logic                               en,
  input  logic [WAVE_WIDTH-1:0]              wavelength_q4,
  output logic [GAMMA_TABLE_BITS+NM_BITS-1:0] lev_m,
  output logic [GAMMA_TABLE_BITS+NM_BITS-1:0] fac_m,
  output div_t                               lev_div,
  output div_t                               fac_div,
  output route_t                             route
);

  localparam int W  = WAVE_FRAC_BITS;
  localparam int G  = GAMMA_TABLE_BITS;
  localparam int NW = NM_BITS + W;                          // numerator width
  localparam int BW = (NW > WAVE_WIDTH) ? NW : WAVE_WIDTH;  // compare width
  localparam int SW = NW + G + 1;                           // dividend width

  localparam logic [BW-1:0] P300 = BW'(WL_UV_START) << W;
  localparam logic [BW-1:0] P380 = BW'(WL_VIOLET) << W;
  localparam logic [BW-1:0] P420 = BW'(WL_FAC_FLAT) << W;
  localparam logic [BW-1:0] P440 = BW'(WL_BLUE) << W;
  localparam logic [BW-1:0] P490 = BW'(WL_CYAN) << W;
  localparam logic [BW-1:0] P510 = BW'(WL_GREEN) << W;
  localparam logic [BW-1:0] P580 = BW'(WL_ORANGE) << W;
  localparam logic [BW-1:0] P645 = BW'(WL_RED) << W;
  localparam logic [BW-1:0] P700 = BW'(WL_FAC_FALL) << W;
  localparam logic [BW-1:0] P780 = BW'(WL_NIR) << W;
  localparam logic [BW-1:0] P781 = BW'(WL_FAC_END) << W;
  localparam logic [BW-1:0] P880 = BW'(WL_IR_END) << W;
  localparam logic [NW-1:0] C_RISE = NW'(FAC_RISE_BASE) << W;
  localparam logic [NW-1:0] C_FALL = NW'(FAC_FALL_BASE) << W;

  logic [BW-1:0] w;
  logic [NW-1:0] lev_num, fac_num, fac_dist;
  logic [SW-1:0] lev_sum, fac_sum;
  div_t          lev_d, fac_d;
  route_t        rt;

  always_comb begin
    w        = BW'(wavelength_q4);
    rt       = '{red: SRC_ZERO, green: SRC_ZERO, blue: SRC_ZERO, factor: FAC_LOW};
    lev_num  = '0;
    fac_num  = '0;
    fac_dist = '0;
    lev_d    = DIV_80;
    fac_d    = DIV_400;
    if (w >= P300 && w < P880) begin
      priority if (w < P380) begin
        rt.red  = SRC_RAMP;
        rt.blue = SRC_RAMP;
        lev_num = NW'(w - P300);
        lev_d   = DIV_80;
      end else if (w < P440) begin
        rt.red  = SRC_RAMP;
        rt.blue = SRC_ONE;
        lev_num = NW'(P440 - w);
        lev_d   = DIV_60;
      end else if (w < P490) begin
        rt.green = SRC_RAMP;
        rt.blue  = SRC_ONE;
        lev_num  = NW'(w - P440);
        lev_d    = DIV_50;
      end else if (w < P510) begin
        rt.green = SRC_ONE;
        rt.blue  = SRC_RAMP;
        lev_num  = NW'(P510 - w);
        lev_d    = DIV_20;
      end else if (w < P580) begin
        rt.red   = SRC_RAMP;
        rt.green = SRC_ONE;
        lev_num  = NW'(w - P510);
        lev_d    = DIV_70;
      end else if (w < P645) begin
        rt.red   = SRC_ONE;
        rt.green = SRC_RAMP;
        lev_num  = NW'(P645 - w);
        lev_d    = DIV_65;
      end else if (w < P780) begin
        rt.red = SRC_ONE;
      end else begin
        // near infrared, may exceed full scale just above 780 nm
        rt.red  = SRC_RAMP;
        lev_num = NW'(P880 - w);
        lev_d   = DIV_99;
      end

      priority if (w < P380) begin
        rt.factor = FAC_LOW;
      end else if (w < P420) begin
        rt.factor = FAC_RAMP;
        fac_dist  = NW'(w - P380);
        fac_num   = C_RISE + (fac_dist << 3) - fac_dist;
        fac_d     = DIV_400;
      end else if (w < P700) begin
        rt.factor = FAC_ONE;
      end else if (w < P781) begin
        // falling ramp runs to 781 nm, dips under the floor past 780 nm
        rt.factor = FAC_RAMP;
        fac_dist  = NW'(P781 - w);
        fac_num   = C_FALL + (fac_dist << 3) - fac_dist;
        fac_d     = DIV_800;
      end else begin
        rt.factor = FAC_LOW;
      end
    end
    // round-half-up dividend: (num * 2^(G+1) + den) / 2^(W+1), den = span * 2^W
    lev_sum = (SW'(lev_num) << (G + 1)) + (SW'(div_span(lev_d)) << W);
    fac_sum = (SW'(fac_num) << (G + 1)) + (SW'(div_span(fac_d)) << W);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lev_m   <= lev_sum[SW-1:W+1];
      fac_m   <= fac_sum[SW-1:W+1];
      lev_div <= lev_d;
      fac_div <= fac_d;
      route   <= rt;
    end
  end

endmodule

### rtl/core/wtr_divide.sv
// Stages 2 and 3: constant division by reciprocal multiply, clamp and channel routing.
module wtr_divide import wtr_pkg::*; #(
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic                                clk,
  input  logic                                en_mul,
  input  logic                                en_quo,
  input  logic [GAMMA_TABLE_BITS+NM_BITS-1:0] lev_m,
  input  logic [GAMMA_TABLE_BITS+NM_BITS-1:0] fac_m,
  input  div_t                                lev_div,
  input  div_t                                fac_div,
  input  route_t                              route,
  output logic [GAMMA_TABLE_BITS:0]           level [3],
  output logic [GAMMA_TABLE_BITS:0]           factor
);

  localparam int G  = GAMMA_TABLE_BITS;
  localparam int MW = G + NM_BITS;
  localparam int K  = MW + SPAN_BITS;   // exact for dividends below 2^MW
  localparam int RW = K - 4;            // reciprocal of spans from 20 up
  localparam int PW = MW + RW;
  localparam int QW = PW - K;

  localparam logic [63:0] TWO_K = 64'd1 << K;
  localparam logic [RW-1:0] R_20  = RW'((TWO_K + 64'd19) / 64'd20);
  localparam logic [RW-1:0] R_50  = RW'((TWO_K + 64'd49) / 64'd50);
  localparam logic [RW-1:0] R_60  = RW'((TWO_K + 64'd59) / 64'd60);
  localparam logic [RW-1:0] R_65  = RW'((TWO_K + 64'd64) / 64'd65);
  localparam logic [RW-1:0] R_70  = RW'((TWO_K + 64'd69) / 64'd70);
  localparam logic [RW-1:0] R_80  = RW'((TWO_K + 64'd79) / 64'd80);
  localparam logic [RW-1:0] R_99  = RW'((TWO_K + 64'd98) / 64'd99);
  localparam logic [RW-1:0] R_400 = RW'((TWO_K + 64'd399) / 64'd400);
  localparam logic [RW-1:0] R_800 = RW'((TWO_K + 64'd799) / 64'd800);

  localparam logic [G:0] ONE   = (G + 1)'(1) << G;
  localparam logic [G:0] LOW_F = (G + 1)'((6 * (1 << G) + 10) / 20);

  function automatic logic [RW-1:0] recip(div_t d);
    unique case (d)
      DIV_20:  recip = R_20;
      DIV_50:  recip = R_50;
      DIV_60:  recip = R_60;
      DIV_65:  recip = R_65;
      DIV_70:  recip = R_70;
      DIV_80:  recip = R_80;
      DIV_99:  recip = R_99;
      DIV_400: recip = R_400;
      DIV_800: recip = R_800;
      default: recip = R_800;
    endcase
  endfunction

  function automatic logic [G:0] clamp(logic [QW-1:0] q);
    clamp = (q > QW'(ONE)) ? ONE : q[G:0];
  endfunction

  function automatic logic [G:0] pick(chan_src_t s, logic [G:0] ramp);
    unique case (s)
      SRC_ZERO: pick = '0;
      SRC_ONE:  pick = ONE;
      SRC_RAMP: pick = ramp;
      default:  pick = '0;
    endcase
  endfunction

  logic [PW-1:0] lev_prod, fac_prod;
  route_t        route_q;
  logic [G:0]    lev_val, fac_val;

  always_ff @(posedge clk) begin
    if (en_mul) begin
      lev_prod <= lev_m * recip(lev_div);
      fac_prod <= fac_m * recip(fac_div);
      route_q  <= route;
    end
  end

  always_comb begin
    lev_val = clamp(lev_prod[PW-1:K]);
    unique case (route_q.factor)
      FAC_LOW:  fac_val = LOW_F;
      FAC_ONE:  fac_val = ONE;
      FAC_RAMP: fac_val = clamp(fac_prod[PW-1:K]);
      default:  fac_val = LOW_F;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en_quo) begin
      level[0] <= pick(route_q.red, lev_val);
      level[1] <= pick(route_q.green, lev_val);
      level[2] <= pick(route_q.blue, lev_val);
      factor   <= fac_val;
    end
  end

endmodule

### rtl/core/wtr_shade.sv
// Stage 4: scale each channel level by the intensity factor, rounded, as a gamma index.
module wtr_shade import wtr_pkg::*; #(
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [GAMMA_TABLE_BITS:0] level [3],
  input  logic [GAMMA_TABLE_BITS:0] factor,
  output logic [GAMMA_TABLE_BITS:0] index [3]
);

  localparam int G  = GAMMA_TABLE_BITS;
  localparam int PW = 2 * G + 2;
  localparam logic [G:0]    ONE  = (G + 1)'(1) << G;
  localparam logic [PW-1:0] HALF = PW'(1) << (G - 1);

  logic [PW-1:0] prod [3];
  logic [G+1:0]  scaled [3];
  logic [G:0]    idx [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c]   = level[c] * factor + HALF;
      scaled[c] = prod[c][PW-1:G];
      idx[c]    = (scaled[c] > (G + 2)'(ONE)) ? ONE : scaled[c][G:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      index <= idx;
    end
  end

endmodule

### rtl/core/wtr_gamma_rom.sv
// Stage 5: gamma 0.8 lookup table, built at elaboration, registered read.
module wtr_gamma_rom #(
  parameter int COLOR_BITS       = 8,
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic                      clk,
  input  logic                      en,
  input  logic [GAMMA_TABLE_BITS:0] addr,
  output logic [COLOR_BITS-1:0]     data
);

  localparam int G      = GAMMA_TABLE_BITS;
  localparam int DEPTH  = (1 << G) + 1;
  localparam int CMAX   = (1 << COLOR_BITS) - 1;
  localparam int BIG    = 160;
  localparam int SEARCH = COLOR_BITS + 3;

  typedef logic [COLOR_BITS-1:0] rom_t [DEPTH];

  // round(CMAX * (i / 2^G)^0.8): largest z with z^5 * 2^(4G) <= 32 * i^4 * CMAX^5
  function automatic logic [COLOR_BITS-1:0] gamma_entry(int unsigned i);
    logic [BIG-1:0] rhs;
    logic [BIG-1:0] lhs;
    int unsigned    lo;
    int unsigned    hi;
    int unsigned    mid;
    rhs = BIG'(32);
    for (int k = 0; k < 4; k++) rhs = rhs * BIG'(i);
    for (int k = 0; k < 5; k++) rhs = rhs * BIG'(CMAX);
    lo = 0;
    hi = 2 * CMAX + 1;
    for (int n = 0; n < SEARCH; n++) begin
      if (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = BIG'(1);
        for (int k = 0; k < 5; k++) lhs = lhs * BIG'(mid);
        lhs = lhs << (4 * G);
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
    end
    lo = (lo + 1) >> 1;
    if (i == 0) lo = 0;
    if (lo > CMAX) lo = CMAX;
    gamma_entry = COLOR_BITS'(lo);
  endfunction

  function automatic rom_t build_rom();
    rom_t t;
    for (int i = 0; i < DEPTH; i++) t[i] = gamma_entry(i);
    build_rom = t;
  endfunction

  localparam rom_t GAMMA = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= GAMMA[addr];
    end
  end

endmodule

### rtl/core/wavelength_to_rgb.sv
// Top level: wavelength (nm, fixed point) to gamma-corrected RGB, five-stage pipeline.
//
//  channel   handshake                  payload                         dir
//  -------   -------------------------  ------------------------------  ---
//  wave      wave_valid / wave_ready    wavelength_q4 [13:0]            in
//  color     color_valid / color_ready  red, green, blue [COLOR_BITS]   out
//
// One transaction per cycle sustained while color_ready is high. Five register
// stages: band decode, reciprocal multiply, quotient and routing, intensity
// multiply, and the gamma table read. The accepting edge loads the first stage,
// and color_valid rises once the word has reached the gamma table read register.
// Reset (rst, synchronous) clears only the stage valid bits; data registers
// are not reset. Each stage holds when it is full and the stage after it
// cannot take, so stalls on color_ready back up stage by stage and empty
// stages keep filling; nothing is dropped or repeated.
module wavelength_to_rgb import wtr_pkg::*; #(
  parameter int WAVE_FRAC_BITS   = 4,
  parameter int COLOR_BITS       = 8,
  parameter int GAMMA_TABLE_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  wave_valid,
  output logic                  wave_ready,
  input  logic [WAVE_WIDTH-1:0] wavelength_q4,
  output logic                  color_valid,
  input  logic                  color_ready,
  output logic [COLOR_BITS-1:0] red,
  output logic [COLOR_BITS-1:0] green,
  output logic [COLOR_BITS-1:0] blue
);

  localparam int G  = GAMMA_TABLE_BITS;
  localparam int MW = G + NM_BITS;

  // per-stage occupancy and load enables
  logic [PIPE_STAGES-1:0] valid;
  logic [PIPE_STAGES-1:0] en;
  logic [PIPE_STAGES-1:0] valid_in;

  // stage 1 -> 2
  logic [MW-1:0] lev_m, fac_m;
  div_t          lev_div, fac_div;
  route_t        route;
  // stage 3 -> 4
  logic [G:0]    level [3];
  logic [G:0]    factor;
  // stage 4 -> 5
  logic [G:0]    index [3];

  // A stage loads when it is empty or its contents move on this cycle.
  always_comb begin
    en[PIPE_STAGES-1] = !valid[PIPE_STAGES-1] || color_ready;
    for (int k = PIPE_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
    valid_in = {valid[PIPE_STAGES-2:0], wave_valid};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < PIPE_STAGES; k++) begin
        if (en[k]) valid[k] <= valid_in[k];
      end
    end
  end

  assign wave_ready  = en[0];
  assign color_valid = valid[PIPE_STAGES-1];

  // band decode and rounded dividends
  wtr_decode #(
    .WAVE_FRAC_BITS  (WAVE_FRAC_BITS),
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_decode (
    .clk          (clk),
    .en           (en[0]),
    .wavelength_q4(wavelength_q4),
    .lev_m        (lev_m),
    .fac_m        (fac_m),
    .lev_div      (lev_div),
    .fac_div      (fac_div),
    .route        (route)
  );

  // ramp level and intensity factor, Q1.G, clamped at full scale
  wtr_divide #(
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_divide (
    .clk    (clk),
    .en_mul (en[1]),
    .en_quo (en[2]),
    .lev_m  (lev_m),
    .fac_m  (fac_m),
    .lev_div(lev_div),
    .fac_div(fac_div),
    .route  (route),
    .level  (level),
    .factor (factor)
  );

  // level times factor, rounded, as a table index
  wtr_shade #(
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_shade (
    .clk   (clk),
    .en    (en[3]),
    .level (level),
    .factor(factor),
    .index (index)
  );

  // one table copy per channel; the read register is the output register
  wtr_gamma_rom #(
    .COLOR_BITS      (COLOR_BITS),
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_gamma_red (
    .clk (clk),
    .en  (en[4]),
    .addr(index[0]),
    .data(red)
  );

  wtr_gamma_rom #(
    .COLOR_BITS      (COLOR_BITS),
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_gamma_green (
    .clk (clk),
    .en  (en[4]),
    .addr(index[1]),
    .data(green)
  );

  wtr_gamma_rom #(
    .COLOR_BITS      (COLOR_BITS),
    .GAMMA_TABLE_BITS(GAMMA_TABLE_BITS)
  ) u_gamma_blue (
    .clk (clk),
    .en  (en[4]),
    .addr(index[2]),
    .data(blue)
  );

endmodule

### rtl/core/wtr_checker.sv
// Port-level checks for wavelength_to_rgb, attached by bind.
module wtr_checker import wtr_pkg::*; #(
  parameter int WAVE_FRAC_BITS = 4,
  parameter int COLOR_BITS     = 8
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  wave_valid,
  input logic                  wave_ready,
  input logic [WAVE_WIDTH-1:0] wavelength_q4,
  input logic                  color_valid,
  input logic                  color_ready,
  input logic [COLOR_BITS-1:0] red,
  input logic [COLOR_BITS-1:0] green,
  input logic [COLOR_BITS-1:0] blue
);

  localparam int LOW_EDGE  = WL_UV_START << WAVE_FRAC_BITS;
  localparam int RED_START = WL_RED << WAVE_FRAC_BITS;
  localparam int RED_END   = WL_FAC_FALL << WAVE_FRAC_BITS;
  localparam logic [COLOR_BITS-1:0] FULL = '1;

  logic wave_take;
  assign wave_take = wave_valid && wave_ready;

  // nothing comes out of reset valid
  a_reset_empty: assert property (@(posedge clk) rst |=> !color_valid)
    else $error("color_valid after reset");

  // an empty output register never back-pressures the input
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !color_valid |-> wave_ready)
    else $error("input stalled with output empty");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    color_valid && !color_ready |=>
      color_valid && $stable(red) && $stable(green) && $stable(blue))
    else $error("stalled color transaction changed");

  // below the ultraviolet edge: black once it reaches the output with no stall
  a_black: assert property (@(posedge clk) disable iff (rst)
    wave_take && (int'(wavelength_q4) < LOW_EDGE)
      ##1 color_ready ##1 color_ready ##1 color_ready ##1 color_ready
      |=> color_valid && red == '0 && green == '0 && blue == '0)
    else $error("out of range wavelength not black");

  // flat red band at full intensity: pure full red
  a_red: assert property (@(posedge clk) disable iff (rst)
    wave_take && (int'(wavelength_q4) >= RED_START) && (int'(wavelength_q4) < RED_END)
      ##1 color_ready ##1 color_ready ##1 color_ready ##1 color_ready
      |=> color_valid && red == FULL && green == '0 && blue == '0)
    else $error("red band not full red");

endmodule

bind wavelength_to_rgb wtr_checker #(
  .WAVE_FRAC_BITS(WAVE_FRAC_BITS),
  .COLOR_BITS    (COLOR_BITS)
) u_wtr_checker (
  .clk          (clk),
  .rst          (rst),
  .wave_valid   (wave_valid),
  .wave_ready   (wave_ready),
  .wavelength_q4(wavelength_q4),
  .color_valid  (color_valid),
  .color_ready  (color_ready),
  .red          (red),
  .green        (green),
  .blue         (blue)
);
